>>> design/wdc_pkg.sv
// ----------------------------------------------------------------------------
// wdc_pkg
// Types, codes and the opcode table of the W65C816 instruction predecoder.
// ----------------------------------------------------------------------------
package wdc_pkg;

   typedef enum logic [4:0] {
      MD_IMPL  = 5'd0,  MD_ACCU  = 5'd1,  MD_IMM8 = 5'd2,  MD_IMMA = 5'd3,
      MD_IMMX  = 5'd4,  MD_DIR   = 5'd5,  MD_DIRX = 5'd6,  MD_DIRY = 5'd7,
      MD_DIND  = 5'd8,  MD_DINX  = 5'd9,  MD_DINY = 5'd10, MD_DLNG = 5'd11,
      MD_DLNY  = 5'd12, MD_ABS   = 5'd13, MD_ABSX = 5'd14, MD_ABSY = 5'd15,
      MD_LONG  = 5'd16, MD_LONX  = 5'd17, MD_AIND = 5'd18, MD_AINX = 5'd19,
      MD_AINL  = 5'd20, MD_STK   = 5'd21, MD_STKY = 5'd22, MD_REL8 = 5'd23,
      MD_REL16 = 5'd24, MD_BLK   = 5'd25
   } mode_type;

   typedef enum logic [2:0] {
      CT_BR = 3'd0, CT_LD = 3'd1, CT_MA = 3'd2, CT_ST = 3'd3, CT_FL = 3'd4, CT_UN = 3'd5
   } cat_type;

   typedef enum logic [2:0] {
      FL_SEQ = 3'd0, FL_COND = 3'd1, FL_JUMP = 3'd2, FL_CALL = 3'd3,
      FL_RET = 3'd4, FL_IND = 3'd5, FL_HALT = 3'd6
   } flow_type;

   typedef struct packed {
      logic [7:0]  opcode_byte;
      logic [7:0]  operand_first;
      logic [7:0]  operand_second;
      logic [7:0]  operand_third;
      logic [23:0] fetch_address;
      logic        accumulator_narrow;
      logic        index_narrow;
      logic [2:0]  bytes_available;
   } req_type;

   typedef struct packed {
      logic        empty_input;
      logic [6:0]  mnemonic_code;
      logic [4:0]  address_mode;
      logic [2:0]  category_code;
      logic [2:0]  flow_class;
      logic [2:0]  instruction_length;
      logic [7:0]  operand_out_first;
      logic [7:0]  operand_out_second;
      logic [7:0]  operand_out_third;
      logic [23:0] target_address;
   } rsp_type;

   typedef struct packed {
      logic [6:0] mn;
      mode_type   md;
      cat_type    ct;
   } op_info_type;

   function automatic op_info_type op_entry(input logic [6:0] mn, input mode_type md,
                                            input cat_type ct);
      op_info_type e;
      e.mn = mn;
      e.md = md;
      e.ct = ct;
      return e;
   endfunction

   // Opcode table: mnemonic, addressing mode and category for each opcode
   function automatic op_info_type op_lookup(input logic [7:0] op);
      op_info_type e;
      case (op)
         8'h00: e = op_entry(0, MD_IMM8, CT_BR);   8'h01: e = op_entry(1, MD_DINX, CT_MA);
         8'h02: e = op_entry(2, MD_IMM8, CT_BR);   8'h03: e = op_entry(1, MD_STK, CT_MA);
         8'h04: e = op_entry(3, MD_DIR, CT_MA);    8'h05: e = op_entry(1, MD_DIR, CT_MA);
         8'h06: e = op_entry(4, MD_DIR, CT_MA);    8'h07: e = op_entry(1, MD_DLNG, CT_MA);
         8'h08: e = op_entry(5, MD_IMPL, CT_ST);   8'h09: e = op_entry(1, MD_IMMA, CT_MA);
         8'h0A: e = op_entry(4, MD_ACCU, CT_MA);   8'h0B: e = op_entry(6, MD_IMPL, CT_ST);
         8'h0C: e = op_entry(3, MD_ABS, CT_MA);    8'h0D: e = op_entry(1, MD_ABS, CT_MA);
         8'h0E: e = op_entry(4, MD_ABS, CT_MA);    8'h0F: e = op_entry(1, MD_LONG, CT_MA);
         8'h10: e = op_entry(7, MD_REL8, CT_BR);   8'h11: e = op_entry(1, MD_DINY, CT_MA);
         8'h12: e = op_entry(1, MD_DIND, CT_MA);   8'h13: e = op_entry(1, MD_STKY, CT_MA);
         8'h14: e = op_entry(8, MD_DIR, CT_MA);    8'h15: e = op_entry(1, MD_DIRX, CT_MA);
         8'h16: e = op_entry(4, MD_DIRX, CT_MA);   8'h17: e = op_entry(1, MD_DLNY, CT_MA);
         8'h18: e = op_entry(9, MD_IMPL, CT_FL);   8'h19: e = op_entry(1, MD_ABSY, CT_MA);
         8'h1A: e = op_entry(10, MD_ACCU, CT_MA);  8'h1B: e = op_entry(11, MD_IMPL, CT_ST);
         8'h1C: e = op_entry(8, MD_ABS, CT_MA);    8'h1D: e = op_entry(1, MD_ABSX, CT_MA);
         8'h1E: e = op_entry(4, MD_ABSX, CT_MA);   8'h1F: e = op_entry(1, MD_LONX, CT_MA);
         8'h20: e = op_entry(12, MD_ABS, CT_BR);   8'h21: e = op_entry(13, MD_DINX, CT_MA);
         8'h22: e = op_entry(14, MD_LONG, CT_BR);  8'h23: e = op_entry(13, MD_STK, CT_MA);
         8'h24: e = op_entry(15, MD_DIR, CT_MA);   8'h25: e = op_entry(13, MD_DIR, CT_MA);
         8'h26: e = op_entry(16, MD_DIR, CT_MA);   8'h27: e = op_entry(13, MD_DLNG, CT_MA);
         8'h28: e = op_entry(17, MD_IMPL, CT_ST);  8'h29: e = op_entry(13, MD_IMMA, CT_MA);
         8'h2A: e = op_entry(16, MD_ACCU, CT_MA);  8'h2B: e = op_entry(18, MD_IMPL, CT_ST);
         8'h2C: e = op_entry(15, MD_ABS, CT_MA);   8'h2D: e = op_entry(13, MD_ABS, CT_MA);
         8'h2E: e = op_entry(16, MD_ABS, CT_MA);   8'h2F: e = op_entry(13, MD_LONG, CT_MA);
         8'h30: e = op_entry(19, MD_REL8, CT_BR);  8'h31: e = op_entry(13, MD_DINY, CT_MA);
         8'h32: e = op_entry(13, MD_DIND, CT_MA);  8'h33: e = op_entry(13, MD_STKY, CT_MA);
         8'h34: e = op_entry(15, MD_DIRX, CT_MA);  8'h35: e = op_entry(13, MD_DIRX, CT_MA);
         8'h36: e = op_entry(16, MD_DIRX, CT_MA);  8'h37: e = op_entry(13, MD_DLNY, CT_MA);
         8'h38: e = op_entry(20, MD_IMPL, CT_FL);  8'h39: e = op_entry(13, MD_ABSY, CT_MA);
         8'h3A: e = op_entry(21, MD_ACCU, CT_MA);  8'h3B: e = op_entry(22, MD_IMPL, CT_ST);
         8'h3C: e = op_entry(15, MD_ABSX, CT_MA);  8'h3D: e = op_entry(13, MD_ABSX, CT_MA);
         8'h3E: e = op_entry(16, MD_ABSX, CT_MA);  8'h3F: e = op_entry(13, MD_LONX, CT_MA);
         8'h40: e = op_entry(23, MD_IMPL, CT_BR);  8'h41: e = op_entry(24, MD_DINX, CT_MA);
         8'h42: e = op_entry(25, MD_IMM8, CT_BR);  8'h43: e = op_entry(24, MD_STK, CT_MA);
         8'h44: e = op_entry(26, MD_BLK, CT_LD);   8'h45: e = op_entry(24, MD_DIR, CT_MA);
         8'h46: e = op_entry(27, MD_DIR, CT_MA);   8'h47: e = op_entry(24, MD_DLNG, CT_MA);
         8'h48: e = op_entry(28, MD_IMPL, CT_ST);  8'h49: e = op_entry(24, MD_IMMA, CT_MA);
         8'h4A: e = op_entry(27, MD_ACCU, CT_MA);  8'h4B: e = op_entry(29, MD_IMPL, CT_ST);
         8'h4C: e = op_entry(30, MD_ABS, CT_BR);   8'h4D: e = op_entry(24, MD_ABS, CT_MA);
         8'h4E: e = op_entry(27, MD_ABS, CT_MA);   8'h4F: e = op_entry(24, MD_LONG, CT_MA);
         8'h50: e = op_entry(31, MD_REL8, CT_BR);  8'h51: e = op_entry(24, MD_DINY, CT_MA);
         8'h52: e = op_entry(24, MD_DIND, CT_MA);  8'h53: e = op_entry(24, MD_STKY, CT_MA);
         8'h54: e = op_entry(32, MD_BLK, CT_LD);   8'h55: e = op_entry(24, MD_DIRX, CT_MA);
         8'h56: e = op_entry(27, MD_DIRX, CT_MA);  8'h57: e = op_entry(24, MD_DLNY, CT_MA);
         8'h58: e = op_entry(33, MD_IMPL, CT_FL);  8'h59: e = op_entry(24, MD_ABSY, CT_MA);
         8'h5A: e = op_entry(34, MD_IMPL, CT_ST);  8'h5B: e = op_entry(35, MD_IMPL, CT_ST);
         8'h5C: e = op_entry(36, MD_LONG, CT_BR);  8'h5D: e = op_entry(24, MD_ABSX, CT_MA);
         8'h5E: e = op_entry(27, MD_ABSX, CT_MA);  8'h5F: e = op_entry(24, MD_LONX, CT_MA);
         8'h60: e = op_entry(37, MD_IMPL, CT_BR);  8'h61: e = op_entry(38, MD_DINX, CT_MA);
         8'h62: e = op_entry(39, MD_REL16, CT_ST); 8'h63: e = op_entry(38, MD_STK, CT_MA);
         8'h64: e = op_entry(40, MD_DIR, CT_LD);   8'h65: e = op_entry(38, MD_DIR, CT_MA);
         8'h66: e = op_entry(41, MD_DIR, CT_MA);   8'h67: e = op_entry(38, MD_DLNG, CT_MA);
         8'h68: e = op_entry(42, MD_IMPL, CT_ST);  8'h69: e = op_entry(38, MD_IMMA, CT_MA);
         8'h6A: e = op_entry(41, MD_ACCU, CT_MA);  8'h6B: e = op_entry(43, MD_IMPL, CT_BR);
         8'h6C: e = op_entry(30, MD_AIND, CT_BR);  8'h6D: e = op_entry(38, MD_ABS, CT_MA);
         8'h6E: e = op_entry(41, MD_ABS, CT_MA);   8'h6F: e = op_entry(38, MD_LONG, CT_MA);
         8'h70: e = op_entry(44, MD_REL8, CT_BR);  8'h71: e = op_entry(38, MD_DINY, CT_MA);
         8'h72: e = op_entry(38, MD_DIND, CT_MA);  8'h73: e = op_entry(38, MD_STKY, CT_MA);
         8'h74: e = op_entry(40, MD_DIRX, CT_LD);  8'h75: e = op_entry(38, MD_DIRX, CT_MA);
         8'h76: e = op_entry(41, MD_DIRX, CT_MA);  8'h77: e = op_entry(38, MD_DLNY, CT_MA);
         8'h78: e = op_entry(45, MD_IMPL, CT_FL);  8'h79: e = op_entry(38, MD_ABSY, CT_MA);
         8'h7A: e = op_entry(46, MD_IMPL, CT_ST);  8'h7B: e = op_entry(47, MD_IMPL, CT_ST);
         8'h7C: e = op_entry(30, MD_AINX, CT_BR);  8'h7D: e = op_entry(38, MD_ABSX, CT_MA);
         8'h7E: e = op_entry(41, MD_ABSX, CT_MA);  8'h7F: e = op_entry(38, MD_LONX, CT_MA);
         8'h80: e = op_entry(48, MD_REL8, CT_BR);  8'h81: e = op_entry(49, MD_DINX, CT_LD);
         8'h82: e = op_entry(50, MD_REL16, CT_BR); 8'h83: e = op_entry(49, MD_STK, CT_LD);
         8'h84: e = op_entry(51, MD_DIR, CT_LD);   8'h85: e = op_entry(49, MD_DIR, CT_LD);
         8'h86: e = op_entry(52, MD_DIR, CT_LD);   8'h87: e = op_entry(49, MD_DLNG, CT_LD);
         8'h88: e = op_entry(53, MD_IMPL, CT_UN);  8'h89: e = op_entry(15, MD_IMMA, CT_MA);
         8'h8A: e = op_entry(54, MD_IMPL, CT_ST);  8'h8B: e = op_entry(55, MD_IMPL, CT_ST);
         8'h8C: e = op_entry(51, MD_ABS, CT_LD);   8'h8D: e = op_entry(49, MD_ABS, CT_LD);
         8'h8E: e = op_entry(52, MD_ABS, CT_LD);   8'h8F: e = op_entry(49, MD_LONG, CT_LD);
         8'h90: e = op_entry(56, MD_REL8, CT_BR);  8'h91: e = op_entry(49, MD_DINY, CT_LD);
         8'h92: e = op_entry(49, MD_DIND, CT_LD);  8'h93: e = op_entry(49, MD_STKY, CT_LD);
         8'h94: e = op_entry(51, MD_DIRX, CT_LD);  8'h95: e = op_entry(49, MD_DIRX, CT_LD);
         8'h96: e = op_entry(52, MD_DIRY, CT_LD);  8'h97: e = op_entry(49, MD_DLNY, CT_LD);
         8'h98: e = op_entry(57, MD_IMPL, CT_ST);  8'h99: e = op_entry(49, MD_ABSY, CT_LD);
         8'h9A: e = op_entry(58, MD_IMPL, CT_ST);  8'h9B: e = op_entry(59, MD_IMPL, CT_ST);
         8'h9C: e = op_entry(40, MD_ABS, CT_LD);   8'h9D: e = op_entry(49, MD_ABSX, CT_LD);
         8'h9E: e = op_entry(40, MD_ABSX, CT_LD);  8'h9F: e = op_entry(49, MD_LONX, CT_LD);
         8'hA0: e = op_entry(60, MD_IMMX, CT_LD);  8'hA1: e = op_entry(61, MD_DINX, CT_LD);
         8'hA2: e = op_entry(62, MD_IMMX, CT_LD);  8'hA3: e = op_entry(61, MD_STK, CT_LD);
         8'hA4: e = op_entry(60, MD_DIR, CT_LD);   8'hA5: e = op_entry(61, MD_DIR, CT_LD);
         8'hA6: e = op_entry(62, MD_DIR, CT_LD);   8'hA7: e = op_entry(61, MD_DLNG, CT_LD);
         8'hA8: e = op_entry(63, MD_IMPL, CT_ST);  8'hA9: e = op_entry(61, MD_IMMA, CT_LD);
         8'hAA: e = op_entry(64, MD_IMPL, CT_ST);  8'hAB: e = op_entry(65, MD_IMPL, CT_ST);
         8'hAC: e = op_entry(60, MD_ABS, CT_LD);   8'hAD: e = op_entry(61, MD_ABS, CT_LD);
         8'hAE: e = op_entry(62, MD_ABS, CT_LD);   8'hAF: e = op_entry(61, MD_LONG, CT_LD);
         8'hB0: e = op_entry(66, MD_REL8, CT_BR);  8'hB1: e = op_entry(61, MD_DINY, CT_LD);
         8'hB2: e = op_entry(61, MD_DIND, CT_LD);  8'hB3: e = op_entry(61, MD_STKY, CT_LD);
         8'hB4: e = op_entry(60, MD_DIRX, CT_LD);  8'hB5: e = op_entry(61, MD_DIRX, CT_LD);
         8'hB6: e = op_entry(62, MD_DIRY, CT_LD);  8'hB7: e = op_entry(61, MD_DLNY, CT_LD);
         8'hB8: e = op_entry(67, MD_IMPL, CT_FL);  8'hB9: e = op_entry(61, MD_ABSY, CT_LD);
         8'hBA: e = op_entry(68, MD_IMPL, CT_ST);  8'hBB: e = op_entry(69, MD_IMPL, CT_ST);
         8'hBC: e = op_entry(60, MD_ABSX, CT_LD);  8'hBD: e = op_entry(61, MD_ABSX, CT_LD);
         8'hBE: e = op_entry(62, MD_ABSY, CT_LD);  8'hBF: e = op_entry(61, MD_LONX, CT_LD);
         8'hC0: e = op_entry(70, MD_IMMX, CT_MA);  8'hC1: e = op_entry(71, MD_DINX, CT_MA);
         8'hC2: e = op_entry(72, MD_IMM8, CT_FL);  8'hC3: e = op_entry(71, MD_STK, CT_MA);
         8'hC4: e = op_entry(70, MD_DIR, CT_MA);   8'hC5: e = op_entry(71, MD_DIR, CT_MA);
         8'hC6: e = op_entry(21, MD_DIR, CT_MA);   8'hC7: e = op_entry(71, MD_DLNG, CT_MA);
         8'hC8: e = op_entry(73, MD_IMPL, CT_UN);  8'hC9: e = op_entry(71, MD_IMMA, CT_MA);
         8'hCA: e = op_entry(74, MD_IMPL, CT_UN);  8'hCB: e = op_entry(75, MD_IMPL, CT_BR);
         8'hCC: e = op_entry(70, MD_ABS, CT_MA);   8'hCD: e = op_entry(71, MD_ABS, CT_MA);
         8'hCE: e = op_entry(21, MD_ABS, CT_MA);   8'hCF: e = op_entry(71, MD_LONG, CT_MA);
         8'hD0: e = op_entry(76, MD_REL8, CT_BR);  8'hD1: e = op_entry(71, MD_DINY, CT_MA);
         8'hD2: e = op_entry(71, MD_DIND, CT_MA);  8'hD3: e = op_entry(71, MD_STKY, CT_MA);
         8'hD4: e = op_entry(77, MD_DIND, CT_ST);  8'hD5: e = op_entry(71, MD_DIRX, CT_MA);
         8'hD6: e = op_entry(21, MD_DIRX, CT_MA);  8'hD7: e = op_entry(71, MD_DLNY, CT_MA);
         8'hD8: e = op_entry(78, MD_IMPL, CT_FL);  8'hD9: e = op_entry(71, MD_ABSY, CT_MA);
         8'hDA: e = op_entry(79, MD_IMPL, CT_ST);  8'hDB: e = op_entry(80, MD_IMPL, CT_BR);
         8'hDC: e = op_entry(36, MD_AINL, CT_BR);  8'hDD: e = op_entry(71, MD_ABSX, CT_MA);
         8'hDE: e = op_entry(21, MD_ABSX, CT_MA);  8'hDF: e = op_entry(71, MD_LONX, CT_MA);
         8'hE0: e = op_entry(81, MD_IMMX, CT_MA);  8'hE1: e = op_entry(82, MD_DINX, CT_MA);
         8'hE2: e = op_entry(83, MD_IMM8, CT_FL);  8'hE3: e = op_entry(82, MD_STK, CT_MA);
         8'hE4: e = op_entry(81, MD_DIR, CT_MA);   8'hE5: e = op_entry(82, MD_DIR, CT_MA);
         8'hE6: e = op_entry(10, MD_DIR, CT_MA);   8'hE7: e = op_entry(82, MD_DLNG, CT_MA);
         8'hE8: e = op_entry(84, MD_IMPL, CT_UN);  8'hE9: e = op_entry(82, MD_IMMA, CT_MA);
         8'hEA: e = op_entry(85, MD_IMPL, CT_ST);  8'hEB: e = op_entry(86, MD_IMPL, CT_LD);
         8'hEC: e = op_entry(81, MD_ABS, CT_MA);   8'hED: e = op_entry(82, MD_ABS, CT_MA);
         8'hEE: e = op_entry(10, MD_ABS, CT_MA);   8'hEF: e = op_entry(82, MD_LONG, CT_MA);
         8'hF0: e = op_entry(87, MD_REL8, CT_BR);  8'hF1: e = op_entry(82, MD_DINY, CT_MA);
         8'hF2: e = op_entry(82, MD_DIND, CT_MA);  8'hF3: e = op_entry(82, MD_STKY, CT_MA);
         8'hF4: e = op_entry(88, MD_ABS, CT_ST);   8'hF5: e = op_entry(82, MD_DIRX, CT_MA);
         8'hF6: e = op_entry(10, MD_DIRX, CT_MA);  8'hF7: e = op_entry(82, MD_DLNY, CT_MA);
         8'hF8: e = op_entry(89, MD_IMPL, CT_FL);  8'hF9: e = op_entry(82, MD_ABSY, CT_MA);
         8'hFA: e = op_entry(90, MD_IMPL, CT_ST);  8'hFB: e = op_entry(91, MD_IMPL, CT_FL);
         8'hFC: e = op_entry(12, MD_AINX, CT_BR);  8'hFD: e = op_entry(82, MD_ABSX, CT_MA);
         8'hFE: e = op_entry(10, MD_ABSX, CT_MA);  8'hFF: e = op_entry(82, MD_LONX, CT_MA);
         default: e = op_entry(0, MD_IMPL, CT_UN);
      endcase
      return e;
   endfunction

   // Control-flow class of an opcode
   function automatic flow_type flow_lookup(input logic [7:0] op);
      flow_type f;
      case (op)
         8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: f = FL_COND;
         8'h80, 8'h82, 8'h4C, 8'h5C: f = FL_JUMP;
         8'h20, 8'h22, 8'hFC:        f = FL_CALL;
         8'h60, 8'h6B, 8'h40:        f = FL_RET;
         8'h6C, 8'h7C, 8'hDC:        f = FL_IND;
         8'h00, 8'h02, 8'hCB, 8'hDB: f = FL_HALT;
         default:                    f = FL_SEQ;
      endcase
      return f;
   endfunction

endpackage

>>> design/wdc65816_instruction_predecoder.sv
// ----------------------------------------------------------------------------
// wdc65816_instruction_predecoder
// Decodes one W65C816 instruction per beat: mnemonic, mode, length, operands
// and branch or jump target.
// ----------------------------------------------------------------------------
//  channel | direction | payload  | handshake
//  req_    | in        | req_type | req_valid / req_stall
//  rsp_    | out       | rsp_type | rsp_valid / rsp_stall
//
// One instruction per cycle while the result is not stalled; the decode (table
// lookup plus a 16-bit target add) is combinational into the result register.
// Reset clears the result valid flag only.
// A stalled result holds; the next beat is accepted into the result register
// as soon as the held one is taken.
module wdc65816_instruction_predecoder (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  wdc_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output wdc_pkg::rsp_type rsp_data
);
   import wdc_pkg::*;

   logic        valid_ff, valid_in;
   rsp_type     data_ff, data_in;
   op_info_type info;
   logic [2:0]  avail;
   logic [1:0]  nops;
   logic [7:0]  op1, op2, op3;
   logic [15:0] offset, word, rel8_off, rel16_off;
   logic [23:0] target;
   logic        accept;

   // Accept whenever the result register is free or being emptied
   assign req_stall = valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Decode one beat
   always_comb begin
      info  = op_lookup(req_data.opcode_byte);
      avail = (req_data.bytes_available > 3'd4) ? 3'd4 : req_data.bytes_available;
      case (info.md)
         MD_IMPL, MD_ACCU: nops = 2'd0;
         MD_IMMA: nops = req_data.accumulator_narrow ? 2'd1 : 2'd2;
         MD_IMMX: nops = req_data.index_narrow ? 2'd1 : 2'd2;
         MD_ABS, MD_ABSX, MD_ABSY, MD_AIND, MD_AINX, MD_AINL, MD_REL16, MD_BLK:
            nops = 2'd2;
         MD_LONG, MD_LONX: nops = 2'd3;
         default: nops = 2'd1;
      endcase
      op1 = (nops >= 2'd1 && avail > 3'd1) ? req_data.operand_first  : 8'h00;
      op2 = (nops >= 2'd2 && avail > 3'd2) ? req_data.operand_second : 8'h00;
      op3 = (nops == 2'd3 && avail > 3'd3) ? req_data.operand_third  : 8'h00;
      offset    = req_data.fetch_address[15:0];
      word      = {op2, op1};
      rel8_off  = offset + 16'd2 + {{8{op1[7]}}, op1};
      rel16_off = offset + 16'd3 + word;
      case (info.md)
         MD_REL8:  target = {req_data.fetch_address[23:16], rel8_off};
         MD_REL16: target = {req_data.fetch_address[23:16], rel16_off};
         MD_ABS, MD_AIND, MD_AINX, MD_AINL:
            target = {req_data.fetch_address[23:16], word};
         MD_LONG, MD_LONX: target = {op3, word};
         default: target = req_data.fetch_address;
      endcase
      data_in = '0;
      data_in.target_address = req_data.fetch_address;
      if (avail == 3'd0) begin
         data_in.empty_input = 1'b1;
      end else begin
         data_in.mnemonic_code      = info.mn;
         data_in.address_mode       = info.md;
         data_in.category_code      = info.ct;
         data_in.flow_class         = flow_lookup(req_data.opcode_byte);
         data_in.instruction_length = {1'b0, nops} + 3'd1;
         data_in.operand_out_first  = op1;
         data_in.operand_out_second = op2;
         data_in.operand_out_third  = op3;
         data_in.target_address     = target;
      end
      valid_in = accept | (valid_ff & rsp_stall);
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // A held result must not change while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_stall |=> valid_ff && $stable(data_ff))
      else $error("result changed under stall");
   // An accepted beat produces a result next cycle
   a_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff)
      else $error("accepted beat lost");
   // Empty results carry no length
   a_empty: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.empty_input |-> data_ff.instruction_length == 3'd0)
      else $error("empty result has length");
   // Non-empty results have length 1..4
   a_len: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.empty_input |->
         data_ff.instruction_length != 3'd0 && data_ff.instruction_length <= 3'd4)
      else $error("bad length");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives opcodes with random operands, flags, fill levels and addresses into
// the predecoder under random idling on both channels, and checks each
// decoded result against a local decode of the same beat.
// ----------------------------------------------------------------------------
module testbench;
   import wdc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 10;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type decode_queue[$];
   int      mismatch_count;
   int      cycle_count;
   int      stall_left;
   bit      quiet_mode;

   wdc65816_instruction_predecoder u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Generate clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Operand byte count from mode and width flags
   function automatic int operand_bytes(mode_type md, logic a8, logic x8);
      case (md)
         MD_IMPL, MD_ACCU: return 0;
         MD_IMMA: return a8 ? 1 : 2;
         MD_IMMX: return x8 ? 1 : 2;
         MD_ABS, MD_ABSX, MD_ABSY, MD_AIND, MD_AINX, MD_AINL, MD_REL16, MD_BLK:
            return 2;
         MD_LONG, MD_LONX: return 3;
         default: return 1;
      endcase
   endfunction

   // Flow class by opcode
   function automatic flow_type opcode_flow(logic [7:0] op);
      case (op)
         8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: return FL_COND;
         8'h80, 8'h82, 8'h4C, 8'h5C: return FL_JUMP;
         8'h20, 8'h22, 8'hFC: return FL_CALL;
         8'h60, 8'h6B, 8'h40: return FL_RET;
         8'h6C, 8'h7C, 8'hDC: return FL_IND;
         8'h00, 8'h02, 8'hCB, 8'hDB: return FL_HALT;
         default: return FL_SEQ;
      endcase
   endfunction

   // Mnemonic/mode/category for one opcode
   function automatic void opcode_info(logic [7:0] op, output logic [6:0] mn,
                                       output mode_type md, output cat_type ct);
      logic [2:0] row;
      row = op[7:5];
      // Regular columns: odd low nibble groups follow the accumulator group
      md = MD_IMPL;
      ct = CT_MA;
      mn = 0;
      case (op)
         8'h00: begin mn = 0;  md = MD_IMM8;  ct = CT_BR; end
         8'h02: begin mn = 2;  md = MD_IMM8;  ct = CT_BR; end
         8'h04: begin mn = 3;  md = MD_DIR; end
         8'h06: begin mn = 4;  md = MD_DIR; end
         8'h08: begin mn = 5;  ct = CT_ST; end
         8'h0A: begin mn = 4;  md = MD_ACCU; end
         8'h0B: begin mn = 6;  ct = CT_ST; end
         8'h0C: begin mn = 3;  md = MD_ABS; end
         8'h0E: begin mn = 4;  md = MD_ABS; end
         8'h10: begin mn = 7;  md = MD_REL8;  ct = CT_BR; end
         8'h14: begin mn = 8;  md = MD_DIR; end
         8'h16: begin mn = 4;  md = MD_DIRX; end
         8'h18: begin mn = 9;  ct = CT_FL; end
         8'h1A: begin mn = 10; md = MD_ACCU; end
         8'h1B: begin mn = 11; ct = CT_ST; end
         8'h1C: begin mn = 8;  md = MD_ABS; end
         8'h1E: begin mn = 4;  md = MD_ABSX; end
         8'h20: begin mn = 12; md = MD_ABS;   ct = CT_BR; end
         8'h22: begin mn = 14; md = MD_LONG;  ct = CT_BR; end
         8'h24: begin mn = 15; md = MD_DIR; end
         8'h26: begin mn = 16; md = MD_DIR; end
         8'h28: begin mn = 17; ct = CT_ST; end
         8'h2A: begin mn = 16; md = MD_ACCU; end
         8'h2B: begin mn = 18; ct = CT_ST; end
         8'h2C: begin mn = 15; md = MD_ABS; end
         8'h2E: begin mn = 16; md = MD_ABS; end
         8'h30: begin mn = 19; md = MD_REL8;  ct = CT_BR; end
         8'h34: begin mn = 15; md = MD_DIRX; end
         8'h36: begin mn = 16; md = MD_DIRX; end
         8'h38: begin mn = 20; ct = CT_FL; end
         8'h3A: begin mn = 21; md = MD_ACCU; end
         8'h3B: begin mn = 22; ct = CT_ST; end
         8'h3C: begin mn = 15; md = MD_ABSX; end
         8'h3E: begin mn = 16; md = MD_ABSX; end
         8'h40: begin mn = 23; ct = CT_BR; end
         8'h42: begin mn = 25; md = MD_IMM8;  ct = CT_BR; end
         8'h44: begin mn = 26; md = MD_BLK;   ct = CT_LD; end
         8'h46: begin mn = 27; md = MD_DIR; end
         8'h48: begin mn = 28; ct = CT_ST; end
         8'h4A: begin mn = 27; md = MD_ACCU; end
         8'h4B: begin mn = 29; ct = CT_ST; end
         8'h4C: begin mn = 30; md = MD_ABS;   ct = CT_BR; end
         8'h4E: begin mn = 27; md = MD_ABS; end
         8'h50: begin mn = 31; md = MD_REL8;  ct = CT_BR; end
         8'h54: begin mn = 32; md = MD_BLK;   ct = CT_LD; end
         8'h56: begin mn = 27; md = MD_DIRX; end
         8'h58: begin mn = 33; ct = CT_FL; end
         8'h5A: begin mn = 34; ct = CT_ST; end
         8'h5B: begin mn = 35; ct = CT_ST; end
         8'h5C: begin mn = 36; md = MD_LONG;  ct = CT_BR; end
         8'h5E: begin mn = 27; md = MD_ABSX; end
         8'h60: begin mn = 37; ct = CT_BR; end
         8'h62: begin mn = 39; md = MD_REL16; ct = CT_ST; end
         8'h64: begin mn = 40; md = MD_DIR;   ct = CT_LD; end
         8'h66: begin mn = 41; md = MD_DIR; end
         8'h68: begin mn = 42; ct = CT_ST; end
         8'h6A: begin mn = 41; md = MD_ACCU; end
         8'h6B: begin mn = 43; ct = CT_BR; end
         8'h6C: begin mn = 30; md = MD_AIND;  ct = CT_BR; end
         8'h6E: begin mn = 41; md = MD_ABS; end
         8'h70: begin mn = 44; md = MD_REL8;  ct = CT_BR; end
         8'h74: begin mn = 40; md = MD_DIRX;  ct = CT_LD; end
         8'h76: begin mn = 41; md = MD_DIRX; end
         8'h78: begin mn = 45; ct = CT_FL; end
         8'h7A: begin mn = 46; ct = CT_ST; end
         8'h7B: begin mn = 47; ct = CT_ST; end
         8'h7C: begin mn = 30; md = MD_AINX;  ct = CT_BR; end
         8'h7E: begin mn = 41; md = MD_ABSX; end
         8'h80: begin mn = 48; md = MD_REL8;  ct = CT_BR; end
         8'h82: begin mn = 50; md = MD_REL16; ct = CT_BR; end
         8'h84: begin mn = 51; md = MD_DIR;   ct = CT_LD; end
         8'h86: begin mn = 52; md = MD_DIR;   ct = CT_LD; end
         8'h88: begin mn = 53; ct = CT_UN; end
         8'h89: begin mn = 15; md = MD_IMMA; end
         8'h8A: begin mn = 54; ct = CT_ST; end
         8'h8B: begin mn = 55; ct = CT_ST; end
         8'h8C: begin mn = 51; md = MD_ABS;   ct = CT_LD; end
         8'h8E: begin mn = 52; md = MD_ABS;   ct = CT_LD; end
         8'h90: begin mn = 56; md = MD_REL8;  ct = CT_BR; end
         8'h94: begin mn = 51; md = MD_DIRX;  ct = CT_LD; end
         8'h96: begin mn = 52; md = MD_DIRY;  ct = CT_LD; end
         8'h98: begin mn = 57; ct = CT_ST; end
         8'h9A: begin mn = 58; ct = CT_ST; end
         8'h9B: begin mn = 59; ct = CT_ST; end
         8'h9C: begin mn = 40; md = MD_ABS;   ct = CT_LD; end
         8'h9E: begin mn = 40; md = MD_ABSX;  ct = CT_LD; end
         8'hA0: begin mn = 60; md = MD_IMMX;  ct = CT_LD; end
         8'hA2: begin mn = 62; md = MD_IMMX;  ct = CT_LD; end
         8'hA4: begin mn = 60; md = MD_DIR;   ct = CT_LD; end
         8'hA6: begin mn = 62; md = MD_DIR;   ct = CT_LD; end
         8'hA8: begin mn = 63; ct = CT_ST; end
         8'hAA: begin mn = 64; ct = CT_ST; end
         8'hAB: begin mn = 65; ct = CT_ST; end
         8'hAC: begin mn = 60; md = MD_ABS;   ct = CT_LD; end
         8'hAE: begin mn = 62; md = MD_ABS;   ct = CT_LD; end
         8'hB0: begin mn = 66; md = MD_REL8;  ct = CT_BR; end
         8'hB4: begin mn = 60; md = MD_DIRX;  ct = CT_LD; end
         8'hB6: begin mn = 62; md = MD_DIRY;  ct = CT_LD; end
         8'hB8: begin mn = 67; ct = CT_FL; end
         8'hBA: begin mn = 68; ct = CT_ST; end
         8'hBB: begin mn = 69; ct = CT_ST; end
         8'hBC: begin mn = 60; md = MD_ABSX;  ct = CT_LD; end
         8'hBE: begin mn = 62; md = MD_ABSY;  ct = CT_LD; end
         8'hC0: begin mn = 70; md = MD_IMMX; end
         8'hC2: begin mn = 72; md = MD_IMM8;  ct = CT_FL; end
         8'hC4: begin mn = 70; md = MD_DIR; end
         8'hC6: begin mn = 21; md = MD_DIR; end
         8'hC8: begin mn = 73; ct = CT_UN; end
         8'hCA: begin mn = 74; ct = CT_UN; end
         8'hCB: begin mn = 75; ct = CT_BR; end
         8'hCC: begin mn = 70; md = MD_ABS; end
         8'hCE: begin mn = 21; md = MD_ABS; end
         8'hD0: begin mn = 76; md = MD_REL8;  ct = CT_BR; end
         8'hD4: begin mn = 77; md = MD_DIND;  ct = CT_ST; end
         8'hD6: begin mn = 21; md = MD_DIRX; end
         8'hD8: begin mn = 78; ct = CT_FL; end
         8'hDA: begin mn = 79; ct = CT_ST; end
         8'hDB: begin mn = 80; ct = CT_BR; end
         8'hDC: begin mn = 36; md = MD_AINL;  ct = CT_BR; end
         8'hDE: begin mn = 21; md = MD_ABSX; end
         8'hE0: begin mn = 81; md = MD_IMMX; end
         8'hE2: begin mn = 83; md = MD_IMM8;  ct = CT_FL; end
         8'hE4: begin mn = 81; md = MD_DIR; end
         8'hE6: begin mn = 10; md = MD_DIR; end
         8'hE8: begin mn = 84; ct = CT_UN; end
         8'hEA: begin mn = 85; ct = CT_ST; end
         8'hEB: begin mn = 86; ct = CT_LD; end
         8'hEC: begin mn = 81; md = MD_ABS; end
         8'hEE: begin mn = 10; md = MD_ABS; end
         8'hF0: begin mn = 87; md = MD_REL8;  ct = CT_BR; end
         8'hF4: begin mn = 88; md = MD_ABS;   ct = CT_ST; end
         8'hF6: begin mn = 10; md = MD_DIRX; end
         8'hF8: begin mn = 89; ct = CT_FL; end
         8'hFA: begin mn = 90; ct = CT_ST; end
         8'hFB: begin mn = 91; ct = CT_FL; end
         8'hFC: begin mn = 12; md = MD_AINX;  ct = CT_BR; end
         8'hFE: begin mn = 10; md = MD_ABSX; end
         default: begin
            // Accumulator group: columns 1,3,5,7,9,D,F,11..1F share one mnemonic per row
            case (row)
               3'd0: mn = 1;
               3'd1: mn = 13;
               3'd2: mn = 24;
               3'd3: mn = 38;
               3'd4: mn = 49;
               3'd5: mn = 61;
               3'd6: mn = 71;
               default: mn = 82;
            endcase
            ct = (row == 3'd4 || row == 3'd5) ? CT_LD : CT_MA;
            case ({op[4], op[3:0]})
               5'h01: md = MD_DINX;  5'h03: md = MD_STK;
               5'h05: md = MD_DIR;   5'h07: md = MD_DLNG;
               5'h09: md = MD_IMMA;  5'h0D: md = MD_ABS;
               5'h0F: md = MD_LONG;  5'h11: md = MD_DINY;
               5'h12: md = MD_DIND;  5'h13: md = MD_STKY;
               5'h15: md = MD_DIRX;  5'h17: md = MD_DLNY;
               5'h19: md = MD_ABSY;  5'h1D: md = MD_ABSX;
               5'h1F: md = MD_LONX;
               default: md = MD_IMPL;
            endcase
         end
      endcase
   endfunction

   // Expected decode of one request beat
   function automatic rsp_type predict_decode(req_type rq);
      rsp_type    r;
      logic [6:0] mn;
      mode_type   md;
      cat_type    ct;
      int         avail;
      int         cnt;
      logic [7:0] b[3];
      logic [15:0] offs;
      logic [15:0] word;
      logic [15:0] disp;
      r = '0;
      r.target_address = rq.fetch_address;
      avail = (rq.bytes_available > 4) ? 4 : rq.bytes_available;
      if (avail == 0) begin
         r.empty_input = 1'b1;
         return r;
      end
      opcode_info(rq.opcode_byte, mn, md, ct);
      cnt = operand_bytes(md, rq.accumulator_narrow, rq.index_narrow);
      b[0] = (cnt > 0 && avail > 1) ? rq.operand_first  : 8'h00;
      b[1] = (cnt > 1 && avail > 2) ? rq.operand_second : 8'h00;
      b[2] = (cnt > 2 && avail > 3) ? rq.operand_third  : 8'h00;
      offs = rq.fetch_address[15:0];
      word = {b[1], b[0]};
      disp = {{8{b[0][7]}}, b[0]};
      case (md)
         MD_REL8:  r.target_address = {rq.fetch_address[23:16], offs + 16'd2 + disp};
         MD_REL16: r.target_address = {rq.fetch_address[23:16], offs + 16'd3 + word};
         MD_ABS, MD_AIND, MD_AINX, MD_AINL:
            r.target_address = {rq.fetch_address[23:16], word};
         MD_LONG, MD_LONX: r.target_address = {b[2], word};
         default: ;
      endcase
      r.mnemonic_code      = mn;
      r.address_mode       = md;
      r.category_code      = ct;
      r.flow_class         = opcode_flow(rq.opcode_byte);
      r.instruction_length = 3'(1 + cnt);
      r.operand_out_first  = b[0];
      r.operand_out_second = b[1];
      r.operand_out_third  = b[2];
      return r;
   endfunction

   // Send one beat, with an optional idle burst first
   task automatic send_beat(req_type rq);
      int gap;
      if (!quiet_mode && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      decode_queue.push_back(predict_decode(rq));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic req_type random_beat();
      req_type rq;
      rq.opcode_byte        = 8'($urandom);
      rq.operand_first      = 8'($urandom);
      rq.operand_second     = 8'($urandom);
      rq.operand_third      = 8'($urandom);
      rq.fetch_address      = 24'($urandom);
      // Keep offsets near the bank edge often to exercise wrap
      if ($urandom_range(0, 3) == 0)
         rq.fetch_address[15:0] = 16'hFFFF - 16'($urandom_range(0, 8));
      rq.accumulator_narrow = 1'($urandom);
      rq.index_narrow       = 1'($urandom);
      // Mostly complete instructions, some truncated, empty or oversized
      case ($urandom_range(0, 9))
         0:       rq.bytes_available = 3'd0;
         1, 2:    rq.bytes_available = 3'($urandom_range(1, 3));
         3:       rq.bytes_available = 3'($urandom_range(5, 7));
         default: rq.bytes_available = 3'd4;
      endcase
      return rq;
   endfunction

   // Every opcode once with full bytes and random width settings
   task automatic test_all_opcodes();
      req_type rq;
      for (int op = 0; op < 256; op++) begin
         rq = random_beat();
         rq.opcode_byte     = 8'(op);
         rq.bytes_available = 3'd4;
         send_beat(rq);
      end
   endtask

   // Field extremes, empty input, truncation, oversized fill, bank wrap
   task automatic test_edge_cases();
      req_type rq;
      rq = '0;
      send_beat(rq);
      rq = '1;
      send_beat(rq);
      rq = '{8'h80, 8'h7F, 8'h00, 8'h00, 24'h12FFFE, 1'b1, 1'b1, 3'd4};
      send_beat(rq);
      rq = '{8'h10, 8'h80, 8'h00, 8'h00, 24'h340001, 1'b0, 1'b0, 3'd2};
      send_beat(rq);
      rq = '{8'h82, 8'hFF, 8'hFF, 8'h00, 24'hABFFFF, 1'b0, 1'b0, 3'd3};
      send_beat(rq);
      rq = '{8'h5C, 8'h34, 8'h12, 8'hFE, 24'h000000, 1'b0, 1'b0, 3'd4};
      send_beat(rq);
      rq = '{8'h5C, 8'h34, 8'h12, 8'hFE, 24'hFFFFFF, 1'b0, 1'b0, 3'd3};
      send_beat(rq);
      rq = '{8'h22, 8'hAA, 8'hBB, 8'hCC, 24'h010203, 1'b0, 1'b0, 3'd1};
      send_beat(rq);
      rq = '{8'hA9, 8'h11, 8'h22, 8'h33, 24'h000100, 1'b1, 1'b0, 3'd7};
      send_beat(rq);
      rq = '{8'hA9, 8'h11, 8'h22, 8'h33, 24'h000100, 1'b0, 1'b1, 3'd5};
      send_beat(rq);
      rq = '{8'hA2, 8'h11, 8'h22, 8'h33, 24'h000100, 1'b0, 1'b1, 3'd6};
      send_beat(rq);
      rq = '{8'hA2, 8'h11, 8'h22, 8'h33, 24'h000100, 1'b1, 1'b0, 3'd4};
      send_beat(rq);
      rq = '{8'hDC, 8'h00, 8'h80, 8'h55, 24'h7F8000, 1'b0, 1'b0, 3'd0};
      send_beat(rq);
      rq = '{8'hEA, 8'h99, 8'h99, 8'h99, 24'h555555, 1'b0, 1'b0, 3'd4};
      send_beat(rq);
   endtask

   task automatic test_random_stream(int count);
      for (int i = 0; i < count; i++) send_beat(random_beat());
   endtask

   // Result stall in random bursts
   always @(posedge clock) begin
      if (reset || quiet_mode) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(1, 16);
      end
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decode_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result beat %h", rsp_data);
         end else begin
            want = decode_queue.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      mismatch_count = 0;
      cycle_count    = 0;
      quiet_mode     = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_cases();
      test_all_opcodes();
      test_random_stream(1100);
      // Final stretch at full rate
      quiet_mode = 1'b1;
      test_random_stream(150);
      req_valid <= 1'b0;
      while (decode_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
